@@ design/bbs_pkg.sv @@
// burst beacon scheduler package: word types, codes and fixed constants
// shared by the serial divider and the top level; depends on nothing
package bbs_pkg;

  localparam int unsigned NowW    = 32;
  localparam int unsigned StampW  = 64;
  localparam int unsigned LenW    = 8;
  localparam int unsigned SpanW   = 16;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDatW = 32;

  localparam logic [SpanW-1:0] MinIntervalMs = SpanW'(20);

  localparam logic [NowW-1:0]  PeriodReset = NowW'(1000);
  localparam logic [LenW-1:0]  BurstReset  = LenW'(1);

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgPeriod = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgBurst  = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CfgSpan   = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CfgDrop   = CfgIdxW'(3);

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_START  = 2'd1,
    KIND_STOP   = 2'd2,
    KIND_ANCHOR = 2'd3
  } bbs_kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_PERIOD,
    S_SEND,
    S_DONE
  } bbs_state_e;

  typedef struct packed {
    logic [1:0]        kind;
    logic [NowW-1:0]   now_ms;
    logic [StampW-1:0] anchor_value_ms;
  } bbs_in_t;

  typedef struct packed {
    logic              send_now;
    logic [StampW-1:0] stamp_ms;
    logic              is_running;
    logic [LenW-1:0]   sends_left;
  } bbs_out_t;

  typedef struct packed {
    logic             start;
    logic [SpanW-1:0] dividend;
    logic [LenW-1:0]  divisor;
  } bbs_div_req_t;

  typedef struct packed {
    logic             done;
    logic [SpanW-1:0] quotient;
  } bbs_div_rsp_t;

endpackage

@@ design/bbs_div.sv @@
// bit-serial restoring divider, one quotient bit per cycle
// uses bbs_pkg for widths and the request/response structs
module bbs_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bbs_pkg::bbs_div_req_t req_i,
  output bbs_pkg::bbs_div_rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(bbs_pkg::SpanW);

  logic                      run_q, run_d;
  logic                      done_q, done_d;
  logic [CntW-1:0]           cnt_q, cnt_d;
  logic [bbs_pkg::SpanW-1:0] quo_q, quo_d;
  logic [bbs_pkg::LenW-1:0]  rem_q, rem_d;
  logic [bbs_pkg::LenW-1:0]  dvs_q, dvs_d;

  logic [bbs_pkg::LenW:0]    shifted;
  logic [bbs_pkg::LenW:0]    diff;
  logic                      qbit;

  always_comb begin
    shifted = {rem_q, quo_q[bbs_pkg::SpanW-1]};
    diff    = shifted - {1'b0, dvs_q};
    qbit    = (shifted >= {1'b0, dvs_q});
  end

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      run_d = 1'b1;
      cnt_d = '0;
      quo_d = req_i.dividend;
      rem_d = '0;
      dvs_d = req_i.divisor;
    end else if (run_q) begin
      rem_d = qbit ? diff[bbs_pkg::LenW-1:0] : shifted[bbs_pkg::LenW-1:0];
      quo_d = {quo_q[bbs_pkg::SpanW-2:0], qbit};
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(bbs_pkg::SpanW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

@@ design/burst_beacon_scheduler_unit.sv @@
// burst beacon scheduler top level: config registers, sequencer, output register
// depends on bbs_pkg and bbs_div
//
//   channel  direction  handshake            word
//   in       input      in_valid_i/in_stall_o   bbs_in_t
//   out      output     out_valid_o/out_stall_i bbs_out_t
//   cfg      input      cfg_valid_i/cfg_ready_o index + 32-bit data
//
// stop, set-anchor and stopped-tick words go straight to the result load; a
// running tick steps through compare period, compare send, load result; a start
// waits on the 16 serial divider steps that turn span into a send interval
// reset clears all scheduler state and loads the register defaults
// a finished result waits in the output register; the next word is taken
// meanwhile, and the sequencer holds in its last step while both are full
module burst_beacon_scheduler_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  bbs_pkg::bbs_in_t             in_word_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output bbs_pkg::bbs_out_t            out_word_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [bbs_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bbs_pkg::CfgDatW-1:0]  cfg_data_i
);

  // configuration registers
  logic [bbs_pkg::NowW-1:0]  period_q;
  logic [bbs_pkg::LenW-1:0]  burst_cfg_q;
  logic [bbs_pkg::SpanW-1:0] span_q;
  logic                      drop_q;

  // scheduler state
  logic                       running_q;
  logic [bbs_pkg::NowW-1:0]   next_period_q;
  logic [bbs_pkg::LenW-1:0]   burst_left_q;
  logic [bbs_pkg::NowW-1:0]   next_send_q;
  logic [bbs_pkg::SpanW-1:0]  interval_q;
  logic [bbs_pkg::StampW-1:0] anchor_abs_q;
  logic [bbs_pkg::NowW-1:0]   anchor_tick_q;

  // per-word working registers
  logic [bbs_pkg::NowW-1:0]   now_q;
  logic [bbs_pkg::NowW-1:0]   elapsed_q;
  logic                       send_q;
  logic [bbs_pkg::StampW-1:0] stamp_q;

  logic                       out_valid_q;
  bbs_pkg::bbs_out_t          out_word_q;

  bbs_pkg::bbs_state_e state_q, state_d;

  logic                      in_accept;
  logic                      out_load;
  logic                      div_start;
  logic [bbs_pkg::LenW-1:0]  eff_len;
  logic [bbs_pkg::SpanW-1:0] interval_new;
  bbs_pkg::bbs_div_req_t     div_req;
  bbs_pkg::bbs_div_rsp_t     div_rsp;

  // zero burst length counts as one
  assign eff_len = (burst_cfg_q == '0) ? bbs_pkg::BurstReset : burst_cfg_q;

  assign interval_new = (div_rsp.quotient < bbs_pkg::MinIntervalMs) ?
                        bbs_pkg::MinIntervalMs : div_rsp.quotient;

  assign div_req.start    = div_start;
  assign div_req.dividend = span_q;
  assign div_req.divisor  = eff_len;

  bbs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bbs_pkg::S_IDLE: begin
        if (in_valid_i) begin
          unique case (in_word_i.kind)
            bbs_pkg::KIND_START: state_d = bbs_pkg::S_DIV;
            bbs_pkg::KIND_TICK:  state_d = running_q ? bbs_pkg::S_PERIOD : bbs_pkg::S_DONE;
            default:             state_d = bbs_pkg::S_DONE;
          endcase
        end
      end
      bbs_pkg::S_DIV: begin
        if (div_rsp.done) begin
          state_d = bbs_pkg::S_DONE;
        end
      end
      bbs_pkg::S_PERIOD: state_d = bbs_pkg::S_SEND;
      bbs_pkg::S_SEND:   state_d = bbs_pkg::S_DONE;
      bbs_pkg::S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = bbs_pkg::S_IDLE;
        end
      end
      default: state_d = bbs_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall_o = 1'b1;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      bbs_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        div_start  = in_valid_i && (in_word_i.kind == bbs_pkg::KIND_START);
      end
      bbs_pkg::S_DONE: out_load = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bbs_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    <= bbs_pkg::PeriodReset;
      burst_cfg_q <= bbs_pkg::BurstReset;
      span_q      <= '0;
      drop_q      <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        bbs_pkg::CfgPeriod: period_q    <= cfg_data_i;
        bbs_pkg::CfgBurst:  burst_cfg_q <= cfg_data_i[bbs_pkg::LenW-1:0];
        bbs_pkg::CfgSpan:   span_q      <= cfg_data_i[bbs_pkg::SpanW-1:0];
        bbs_pkg::CfgDrop:   drop_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // scheduler state updates, one step per sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q     <= 1'b0;
      next_period_q <= '0;
      burst_left_q  <= '0;
      next_send_q   <= '0;
      interval_q    <= '0;
      anchor_abs_q  <= '0;
      anchor_tick_q <= '0;
    end else begin
      unique case (state_q)
        bbs_pkg::S_IDLE: begin
          if (in_accept) begin
            unique case (in_word_i.kind)
              bbs_pkg::KIND_STOP: running_q <= 1'b0;
              bbs_pkg::KIND_ANCHOR: begin
                anchor_abs_q  <= in_word_i.anchor_value_ms;
                anchor_tick_q <= in_word_i.now_ms;
              end
              default: ;
            endcase
          end
        end
        bbs_pkg::S_DIV: begin
          // start lands once the interval is known
          if (div_rsp.done) begin
            running_q     <= 1'b1;
            next_period_q <= now_q;
            interval_q    <= interval_new;
            burst_left_q  <= '0;
            next_send_q   <= now_q;
          end
        end
        bbs_pkg::S_PERIOD: begin
          if (now_q >= next_period_q) begin
            next_period_q <= now_q + period_q;
            if (!drop_q) begin
              burst_left_q <= eff_len;
              next_send_q  <= now_q;
            end
          end
        end
        bbs_pkg::S_SEND: begin
          if ((burst_left_q != '0) && (now_q >= next_send_q)) begin
            burst_left_q <= burst_left_q - bbs_pkg::LenW'(1);
            next_send_q  <= next_send_q + bbs_pkg::NowW'(interval_q);
          end
        end
        default: ;
      endcase
    end
  end

  // per-word working registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      send_q <= 1'b0;
    end else if (in_accept) begin
      send_q <= 1'b0;
    end else if (state_q == bbs_pkg::S_SEND) begin
      send_q <= (burst_left_q != '0) && (now_q >= next_send_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      now_q   <= in_word_i.now_ms;
      stamp_q <= '0;
    end else if (state_q == bbs_pkg::S_PERIOD) begin
      // elapsed ticks wrap modulo the counter width
      elapsed_q <= now_q - anchor_tick_q;
    end else if (state_q == bbs_pkg::S_SEND) begin
      if ((burst_left_q != '0) && (now_q >= next_send_q)) begin
        stamp_q <= anchor_abs_q + bbs_pkg::StampW'(elapsed_q);
      end
    end
  end

  // output register, loaded when empty or being drained
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_word_q.send_now   <= send_q;
      out_word_q.stamp_ms   <= stamp_q;
      out_word_q.is_running <= running_q;
      out_word_q.sends_left <= burst_left_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule
